// ===== design/bcbc_pkg.sv =====
// ============================================================================
// bcbc_pkg
// Types and constants shared by the blink-code button controller.
// ============================================================================
`default_nettype none

package bcbc_pkg;

   localparam int TIME_BITS = 16;
   localparam int CFG_BITS  = 16;
   localparam int CMP_BITS  = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
   localparam int IDX_BITS  = 3;

   localparam logic [IDX_BITS-1:0] REG_DEBOUNCE_MS   = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_MIN_PRESS_MS  = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_LONG_PRESS_MS = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_PAUSE_TICKS   = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_MIN_BLINKS    = 3'd4;
   localparam logic [IDX_BITS-1:0] REG_MAX_BLINKS    = 3'd5;

   localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [15:0] MIN_PRESS_RESET  = 16'd30;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd3000;
   localparam logic [7:0]  PAUSE_RESET      = 8'd5;
   localparam logic [2:0]  MIN_BLINKS_RESET = 3'd4;
   localparam logic [2:0]  MAX_BLINKS_RESET = 3'd7;
   localparam logic [2:0]  BLINKS_RESET     = 3'd4;

   typedef struct packed {
      logic button_fall;
      logic button_high;
      logic blink_tick;
   } req_type;

   typedef struct packed {
      logic       led_on;
      logic [2:0] blink_count;
      logic       in_pause;
      logic       short_press;
      logic       long_press;
   } rsp_type;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] min_press_ms;
      logic [15:0] long_press_ms;
      logic [7:0]  pause_ticks;
      logic [2:0]  min_blinks;
      logic [2:0]  max_blinks;
   } cfg_type;

   typedef struct packed {
      logic short_press;
      logic long_press;
   } press_ev_type;

endpackage

`default_nettype wire

// ===== design/bcbc_csr.sv =====
// ============================================================================
// bcbc_csr
// Configuration register file, written one register per beat.
// ============================================================================
`default_nettype none

module bcbc_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire logic [bcbc_pkg::IDX_BITS-1:0] wr_index,
   input  wire logic [bcbc_pkg::CFG_BITS-1:0] wr_data,
   output bcbc_pkg::cfg_type                 cfg
);
   import bcbc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_DEBOUNCE_MS:   cfg_in.debounce_ms   = wr_data;
            REG_MIN_PRESS_MS:  cfg_in.min_press_ms  = wr_data;
            REG_LONG_PRESS_MS: cfg_in.long_press_ms = wr_data;
            REG_PAUSE_TICKS:   cfg_in.pause_ticks   = wr_data[7:0];
            REG_MIN_BLINKS:    cfg_in.min_blinks    = wr_data[2:0];
            REG_MAX_BLINKS:    cfg_in.max_blinks    = wr_data[2:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DEBOUNCE_RESET;
         cfg_ff.min_press_ms  <= MIN_PRESS_RESET;
         cfg_ff.long_press_ms <= LONG_PRESS_RESET;
         cfg_ff.pause_ticks   <= PAUSE_RESET;
         cfg_ff.min_blinks    <= MIN_BLINKS_RESET;
         cfg_ff.max_blinks    <= MAX_BLINKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/bcbc_press.sv =====
// ============================================================================
// bcbc_press
// Button timing: debounce window, press hold time, short and long press events.
// ============================================================================
`default_nettype none

module bcbc_press (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire bcbc_pkg::req_type  item,
   input  wire bcbc_pkg::cfg_type  cfg,
   output bcbc_pkg::press_ev_type ev
);
   import bcbc_pkg::*;

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   logic [TIME_BITS-1:0] since_fall_ff, since_fall_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;
   logic                 active_ff, active_in;
   logic                 long_done_ff, long_done_in;

   logic [TIME_BITS-1:0] since_inc, elapsed_inc;
   logic                 fall_ok, start;
   logic [CMP_BITS-1:0]  elapsed_w;

   always_comb begin
      since_inc   = (since_fall_ff == TIME_MAX) ? TIME_MAX : since_fall_ff + 1'b1;
      elapsed_inc = elapsed_ff;
      if (active_ff && elapsed_ff != TIME_MAX) begin
         elapsed_inc = elapsed_ff + 1'b1;
      end

      fall_ok = item.button_fall && (CMP_BITS'(since_inc) >= CMP_BITS'(cfg.debounce_ms));
      start   = fall_ok && !active_ff;

      since_fall_in = fall_ok ? '0 : since_inc;
      active_in     = active_ff || fall_ok;
      elapsed_in    = start ? '0 : elapsed_inc;
      long_done_in  = start ? 1'b0 : long_done_ff;
      elapsed_w     = CMP_BITS'(elapsed_in);

      ev = '0;
      if (active_in && item.button_high) begin
         ev.short_press = !long_done_in
                          && elapsed_w >= CMP_BITS'(cfg.min_press_ms)
                          && elapsed_w <  CMP_BITS'(cfg.long_press_ms);
         active_in    = 1'b0;
         long_done_in = 1'b0;
      end

      if (active_in && !long_done_in && elapsed_w >= CMP_BITS'(cfg.long_press_ms)) begin
         long_done_in  = 1'b1;
         ev.long_press = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         since_fall_ff <= '0;
         elapsed_ff    <= '0;
         active_ff     <= 1'b0;
         long_done_ff  <= 1'b0;
      end else if (step) begin
         since_fall_ff <= since_fall_in;
         elapsed_ff    <= elapsed_in;
         active_ff     <= active_in;
         long_done_ff  <= long_done_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/bcbc_blink.sv =====
// ============================================================================
// bcbc_blink
// Blink pattern sequencer and blink count; forms the next result beat.
// ============================================================================
`default_nettype none

module bcbc_blink (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic              tick,
   input  wire bcbc_pkg::press_ev_type ev,
   input  wire bcbc_pkg::cfg_type      cfg,
   output bcbc_pkg::rsp_type      rsp
);
   import bcbc_pkg::*;

   logic       led_ff, led_in;
   logic [2:0] done_ff, done_in;
   logic       pausing_ff, pausing_in;
   logic [7:0] pcount_ff, pcount_in;
   logic [2:0] count_ff, count_in;

   logic [7:0] pcount_inc;
   logic [2:0] done_inc;

   always_comb begin
      led_in     = led_ff;
      done_in    = done_ff;
      pausing_in = pausing_ff;
      pcount_in  = pcount_ff;
      count_in   = count_ff;
      pcount_inc = (pcount_ff == 8'hFF) ? 8'hFF : pcount_ff + 1'b1;
      done_inc   = (done_ff == 3'd7) ? 3'd7 : done_ff + 1'b1;

      if (tick) begin
         if (pausing_ff) begin
            pcount_in = pcount_inc;
            if (pcount_inc >= cfg.pause_ticks) begin
               pausing_in = 1'b0;
               pcount_in  = '0;
               done_in    = '0;
               led_in     = 1'b0;
            end
         end else if (!led_ff) begin
            led_in = 1'b1;
         end else begin
            led_in  = 1'b0;
            done_in = done_inc;
            if (done_inc >= count_ff) begin
               pausing_in = 1'b1;
               pcount_in  = '0;
            end
         end
      end

      if (ev.long_press || ev.short_press) begin
         led_in     = 1'b0;
         done_in    = '0;
         pausing_in = 1'b0;
         pcount_in  = '0;
         if (ev.long_press || count_ff >= cfg.max_blinks) begin
            count_in = cfg.min_blinks;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end

      rsp.led_on      = led_in;
      rsp.blink_count = count_in;
      rsp.in_pause    = pausing_in;
      rsp.short_press = ev.short_press;
      rsp.long_press  = ev.long_press;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff     <= 1'b0;
         done_ff    <= '0;
         pausing_ff <= 1'b0;
         pcount_ff  <= '0;
         count_ff   <= BLINKS_RESET;
      end else if (step) begin
         led_ff     <= led_in;
         done_ff    <= done_in;
         pausing_ff <= pausing_in;
         pcount_ff  <= pcount_in;
         count_ff   <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/blink_code_button_controller.sv =====
// ============================================================================
// blink_code_button_controller
// Millisecond-tick driven LED blink code with button debounce and press
// classification.
//
//   channel | ports                          | carries
//   --------+--------------------------------+------------------------------
//   req     | req_valid req_ready req_data   | one ms tick: fall, level, tick
//   rsp     | rsp_valid rsp_ready rsp_data   | LED, count, pause, press pulses
//   csr     | csr_valid csr_ready csr_index  | register write, index 0..5
//           | csr_wdata                      |
//
// One beat per cycle sustained while rsp is ready; a beat accepted on req is
// offered on rsp after passing the input register, then the result register.
// State updates as the beat moves from the input to the result register. A
// stalled rsp holds both registers, and req_ready drops only then. Synchronous
// reset empties both registers and resets other state; csr is always ready.
// ============================================================================
`default_nettype none

module blink_code_button_controller (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire bcbc_pkg::req_type            req_data,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output bcbc_pkg::rsp_type                 rsp_data,
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire logic [bcbc_pkg::IDX_BITS-1:0] csr_index,
   input  wire logic [bcbc_pkg::CFG_BITS-1:0] csr_wdata
);
   import bcbc_pkg::*;

   logic         in_valid_ff;
   req_type      in_data_ff;
   logic         out_valid_ff;
   rsp_type      out_data_ff;
   logic         advance;
   cfg_type      cfg;
   press_ev_type ev;
   rsp_type      rsp_in;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   bcbc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   bcbc_press u_press (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_data_ff),
      .cfg   (cfg),
      .ev    (ev)
   );

   bcbc_blink u_blink (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .tick  (in_data_ff.blink_tick),
      .ev    (ev),
      .cfg   (cfg),
      .rsp   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== design/bcbc_checker.sv =====
// ============================================================================
// bcbc_checker
// Port-level checks for the blink-code button controller.
// ============================================================================
`default_nettype none

module bcbc_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire bcbc_pkg::rsp_type  rsp_data
);
   import bcbc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   a_press_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.short_press && rsp_data.long_press))
      else $error("short and long press in one beat");

   a_press_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.short_press || rsp_data.long_press)
         |-> !rsp_data.led_on && !rsp_data.in_pause)
      else $error("press event did not restart the pattern");

   a_pause_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.in_pause |-> !rsp_data.led_on)
      else $error("LED lit during pause");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind blink_code_button_controller bcbc_checker u_bcbc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
